>>> hw/rtl/tcce_pkg.sv
// Shared types and constants for the text console cursor engine.
// Holds the character codes, the result field widths and the write result struct.
// No dependencies.
`timescale 1ns / 1ps

package tcce_pkg;

  localparam int unsigned CHAR_W = 8;
  localparam int unsigned ATTR_W = 8;
  localparam int unsigned COL_W  = 7;
  localparam int unsigned ROW_W  = 5;
  localparam int unsigned POS_W  = 11;

  localparam logic [CHAR_W-1:0] CHAR_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CHAR_TAB       = 8'd9;
  localparam logic [CHAR_W-1:0] CHAR_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CHAR_SPACE     = 8'd32;
  localparam logic [ATTR_W-1:0] ATTR_RESET     = 8'h0f;

  // Cell write and scroll request produced for one item.
  typedef struct packed {
    logic              write_enable;
    logic [COL_W-1:0]  write_col;
    logic [ROW_W-1:0]  write_row;
    logic [CHAR_W-1:0] write_char;
    logic [ATTR_W-1:0] write_attr;
    logic              scroll_up;
  } res_t;

endpackage

>>> hw/rtl/tcce_step.sv
// Next-cursor logic for one character of the text console cursor engine.
// Decodes the character, moves the cursor and forms the cell write and scroll request.
// Depends on tcce_pkg.
`timescale 1ns / 1ps

module tcce_step #(
  parameter int unsigned COLUMNS   = 80,
  parameter int unsigned ROWS      = 25,
  parameter int unsigned TAB_WIDTH = 8,
  localparam int unsigned ColW = $clog2(COLUMNS),
  localparam int unsigned RowW = (ROWS > 2) ? $clog2(ROWS) : 1,
  localparam int unsigned TabW = $clog2(TAB_WIDTH)
) (
  input  logic [tcce_pkg::CHAR_W-1:0] char_i,
  input  logic [tcce_pkg::ATTR_W-1:0] attr_i,
  input  logic [ColW-1:0]             col_i,
  input  logic [RowW-1:0]             row_i,
  input  logic [TabW-1:0]             phase_i,
  output logic [ColW-1:0]             col_o,
  output logic [RowW-1:0]             row_o,
  output logic [TabW-1:0]             phase_o,
  output logic [tcce_pkg::POS_W-1:0]  pos_o,
  output tcce_pkg::res_t              res_o
);
  import tcce_pkg::*;

  // Wide enough for a column that has run past the row end by up to one tab.
  localparam int unsigned XW   = $clog2(COLUMNS + TAB_WIDTH);
  localparam int unsigned YW   = RowW + 1;
  localparam int unsigned PosW = $clog2(ROWS * COLUMNS);

  localparam logic [XW-1:0]   ColLim   = XW'(COLUMNS);
  localparam logic [XW-1:0]   ColLast  = XW'(COLUMNS - 1);
  localparam logic [XW-1:0]   TabStep  = XW'(TAB_WIDTH);
  localparam logic [YW-1:0]   RowLim   = YW'(ROWS);
  localparam logic [YW-1:0]   RowLast  = YW'(ROWS - 1);
  localparam logic [TabW-1:0] TabLast  = TabW'(TAB_WIDTH - 1);
  localparam logic [TabW-1:0] BsPhase  = TabW'((COLUMNS - 1) % TAB_WIDTH);
  localparam logic [PosW-1:0] PosCols  = PosW'(COLUMNS);

  logic [XW-1:0]   x;
  logic [YW-1:0]   y;
  logic [TabW-1:0] ph;
  logic [PosW-1:0] pos;

  always_comb begin
    x     = XW'(col_i);
    y     = YW'(row_i);
    ph    = phase_i;
    res_o = '0;

    unique case (char_i)
      CHAR_NEWLINE: begin
        x  = '0;
        y  = y + YW'(1);
        ph = '0;
      end
      CHAR_TAB: begin
        // The phase is the column modulo the tab width; aligned columns stay put.
        if (phase_i != '0) begin
          x = x + (TabStep - XW'(phase_i));
        end
        ph = '0;
      end
      CHAR_BACKSPACE: begin
        if (col_i == '0) begin
          x  = ColLast;
          ph = BsPhase;
          if (row_i != '0) begin
            y = y - YW'(1);
          end
        end else begin
          x  = x - XW'(1);
          ph = (phase_i == '0) ? TabLast : phase_i - TabW'(1);
        end
        res_o.write_enable = 1'b1;
        res_o.write_col    = COL_W'(x);
        res_o.write_row    = ROW_W'(y);
        res_o.write_char   = CHAR_SPACE;
        res_o.write_attr   = attr_i;
      end
      default: begin
        res_o.write_enable = 1'b1;
        res_o.write_col    = COL_W'(col_i);
        res_o.write_row    = ROW_W'(row_i);
        res_o.write_char   = char_i;
        res_o.write_attr   = attr_i;
        x  = x + XW'(1);
        ph = (phase_i == TabLast) ? '0 : phase_i + TabW'(1);
      end
    endcase

    if (x >= ColLim) begin
      x  = '0;
      y  = y + YW'(1);
      ph = '0;
    end
    if (y >= RowLim) begin
      res_o.scroll_up = 1'b1;
      x  = '0;
      y  = RowLast;
      ph = '0;
    end
  end

  assign col_o   = ColW'(x);
  assign row_o   = RowW'(y);
  assign phase_o = ph;
  assign pos     = PosW'(y) * PosCols + PosW'(x);
  assign pos_o   = POS_W'(pos);

endmodule

>>> hw/rtl/text_console_cursor_engine_core.sv
// Text console cursor engine: one character in, one cursor and cell write result out.
// An accepted item is registered in the input register, then its result is registered in the
// result register and offered from there. Throughput is one item per cycle while the output
// does not stall, set by the cursor update, whose loop through tcce_step is combinational.
// Reset clears the cursor to column 0 of row 0, empties both stages and sets the attribute
// to 0x0f. Depends on tcce_pkg and tcce_step.
`timescale 1ns / 1ps

module text_console_cursor_engine_core #(
  parameter int unsigned COLUMNS   = 80,
  parameter int unsigned ROWS      = 25,
  parameter int unsigned TAB_WIDTH = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Configuration write channel.
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [tcce_pkg::ATTR_W-1:0] cfg_data_i,
  // Character input.
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [tcce_pkg::CHAR_W-1:0] char_code_i,
  // Result output.
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        write_enable_o,
  output logic [tcce_pkg::COL_W-1:0]  write_col_o,
  output logic [tcce_pkg::ROW_W-1:0]  write_row_o,
  output logic [tcce_pkg::CHAR_W-1:0] write_char_o,
  output logic [tcce_pkg::ATTR_W-1:0] write_attr_o,
  output logic                        scroll_up_o,
  output logic [tcce_pkg::COL_W-1:0]  cursor_col_o,
  output logic [tcce_pkg::ROW_W-1:0]  cursor_row_o,
  output logic [tcce_pkg::POS_W-1:0]  cursor_pos_o
);
  import tcce_pkg::*;

  localparam int unsigned ColW = $clog2(COLUMNS);
  localparam int unsigned RowW = (ROWS > 2) ? $clog2(ROWS) : 1;
  localparam int unsigned TabW = $clog2(TAB_WIDTH);

  logic              in_valid_q, in_valid_d;
  logic [CHAR_W-1:0] char_q;
  logic              out_valid_q, out_valid_d;
  res_t              res_q;
  logic [POS_W-1:0]  pos_q;
  logic [ATTR_W-1:0] attr_q;
  logic [ColW-1:0]   col_q, col_d;
  logic [RowW-1:0]   row_q, row_d;
  logic [TabW-1:0]   phase_q, phase_d;
  logic [POS_W-1:0]  pos_d;
  res_t              res_d;

  logic in_accept;
  logic out_free;
  logic advance;

  assign cfg_ready_o = 1'b1;

  // The result register frees up in the same cycle that its item is taken.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign in_valid_d  = in_accept || (in_valid_q && !advance);
  assign out_valid_d = advance || (out_valid_q && out_stall_i);

  tcce_step #(
    .COLUMNS  (COLUMNS),
    .ROWS     (ROWS),
    .TAB_WIDTH(TAB_WIDTH)
  ) u_step (
    .char_i (char_q),
    .attr_i (attr_q),
    .col_i  (col_q),
    .row_i  (row_q),
    .phase_i(phase_q),
    .col_o  (col_d),
    .row_o  (row_d),
    .phase_o(phase_d),
    .pos_o  (pos_d),
    .res_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      attr_q      <= ATTR_RESET;
      col_q       <= '0;
      row_q       <= '0;
      phase_q     <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        attr_q <= cfg_data_i;
      end
      if (advance) begin
        col_q   <= col_d;
        row_q   <= row_d;
        phase_q <= phase_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      char_q <= char_code_i;
    end
    if (advance) begin
      res_q <= res_d;
      pos_q <= pos_d;
    end
  end

  // The cursor registers always hold the cursor after the item in the result register.
  assign out_valid_o    = out_valid_q;
  assign write_enable_o = res_q.write_enable;
  assign write_col_o    = res_q.write_col;
  assign write_row_o    = res_q.write_row;
  assign write_char_o   = res_q.write_char;
  assign write_attr_o   = res_q.write_attr;
  assign scroll_up_o    = res_q.scroll_up;
  assign cursor_col_o   = COL_W'(col_q);
  assign cursor_row_o   = ROW_W'(row_q);
  assign cursor_pos_o   = pos_q;

`ifndef SYNTHESIS
  a_advance_fills_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("item in the input register was not moved to the result register");

  a_scroll_homes_cursor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.scroll_up) |-> (col_q == '0 && 32'(row_q) == ROWS - 1))
    else $error("scroll request without the cursor at the start of the last row");

  a_cursor_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (32'(col_q) < COLUMNS && 32'(row_q) < ROWS))
    else $error("cursor left the screen");

  a_pos_matches_cursor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (pos_q == POS_W'(32'(row_q) * COLUMNS + 32'(col_q))))
    else $error("linear position does not match the cursor");

  a_no_write_fields_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !res_q.write_enable) |-> (res_q.write_char == '0 && res_q.write_col == '0))
    else $error("write fields set on an item that writes no cell");
`endif

endmodule

>>> verif/tb.sv
// Testbench for text_console_cursor_engine_core: streams character items and checks each
// cursor and cell write result against a cursor predictor kept in a scoreboard class.
// Depends on tcce_pkg and the core RTL.
`timescale 1ns / 1ps

module tb;
  import tcce_pkg::*;

  localparam int unsigned COLUMNS         = 80;
  localparam int unsigned ROWS            = 25;
  localparam int unsigned TAB_WIDTH       = 8;
  localparam int unsigned NUM_PHASES      = 5;
  localparam int unsigned ITEMS_PER_PHASE = 190;
  localparam int unsigned DRAIN_CYCLES    = 10;
  localparam int unsigned CYCLE_LIMIT     = 600000;
  localparam int unsigned NUM_DIRECTED    = 15;

  typedef struct packed {
    res_t             wr;
    logic [COL_W-1:0] cur_col;
    logic [ROW_W-1:0] cur_row;
    logic [POS_W-1:0] cur_pos;
  } cursor_result_t;

  class cursor_scoreboard;
    logic [ATTR_W-1:0] attr;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    cursor_result_t    expected_q[$];
    int unsigned       mismatches;
    int unsigned       results_seen;

    function new();
      attr         = ATTR_RESET;
      col          = '0;
      row          = '0;
      mismatches   = 0;
      results_seen = 0;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // Advances the cursor for one accepted character and queues the result it must cause.
    function void note_char(logic [CHAR_W-1:0] c);
      cursor_result_t r;
      int unsigned    x;
      int unsigned    y;
      r = '0;
      x = col;
      y = row;
      if (c == CHAR_NEWLINE) begin
        x = 0;
        y = y + 1;
      end else if (c == CHAR_TAB) begin
        x = ((x + TAB_WIDTH - 1) / TAB_WIDTH) * TAB_WIDTH;
      end else if (c == CHAR_BACKSPACE) begin
        if (x == 0) begin
          x = COLUMNS - 1;
          if (y > 0) y = y - 1;
        end else begin
          x = x - 1;
        end
        r.wr.write_enable = 1'b1;
        r.wr.write_col    = COL_W'(x);
        r.wr.write_row    = ROW_W'(y);
        r.wr.write_char   = CHAR_SPACE;
        r.wr.write_attr   = attr;
      end else begin
        r.wr.write_enable = 1'b1;
        r.wr.write_col    = COL_W'(x);
        r.wr.write_row    = ROW_W'(y);
        r.wr.write_char   = c;
        r.wr.write_attr   = attr;
        x = x + 1;
      end
      if (x >= COLUMNS) begin
        x = 0;
        y = y + 1;
      end
      if (y >= ROWS) begin
        r.wr.scroll_up = 1'b1;
        x = 0;
        y = ROWS - 1;
      end
      col       = COL_W'(x);
      row       = ROW_W'(y);
      r.cur_col = COL_W'(x);
      r.cur_row = ROW_W'(y);
      r.cur_pos = POS_W'(y * COLUMNS + x);
      expected_q.push_back(r);
    endfunction

    task report(string msg);
      $display("mismatch at result %0d: %s", results_seen, msg);
      mismatches++;
    endtask

    task compare_field(string name, int unsigned got, int unsigned want);
      if (got != want) report($sformatf("%s is %0d, expected %0d", name, got, want));
    endtask

    task check_result(cursor_result_t got);
      cursor_result_t want;
      results_seen++;
      if (expected_q.size() == 0) begin
        report("result with no item outstanding");
      end else begin
        want = expected_q.pop_front();
        compare_field("write_enable", got.wr.write_enable, want.wr.write_enable);
        compare_field("write_col", got.wr.write_col, want.wr.write_col);
        compare_field("write_row", got.wr.write_row, want.wr.write_row);
        compare_field("write_char", got.wr.write_char, want.wr.write_char);
        compare_field("write_attr", got.wr.write_attr, want.wr.write_attr);
        compare_field("scroll_up", got.wr.scroll_up, want.wr.scroll_up);
        compare_field("cursor_col", got.cur_col, want.cur_col);
        compare_field("cursor_row", got.cur_row, want.cur_row);
        compare_field("cursor_pos", got.cur_pos, want.cur_pos);
      end
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [ATTR_W-1:0] cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [CHAR_W-1:0] char_code = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              write_enable;
  logic [COL_W-1:0]  write_col;
  logic [ROW_W-1:0]  write_row;
  logic [CHAR_W-1:0] write_char;
  logic [ATTR_W-1:0] write_attr;
  logic              scroll_up;
  logic [COL_W-1:0]  cursor_col;
  logic [ROW_W-1:0]  cursor_row;
  logic [POS_W-1:0]  cursor_pos;
  cursor_result_t    dut_result;

  cursor_scoreboard  sb;
  int unsigned       cycle_count = 0;
  int unsigned       stall_left = 0;
  logic              stall_on = 1'b0;

  text_console_cursor_engine_core #(
    .COLUMNS  (COLUMNS),
    .ROWS     (ROWS),
    .TAB_WIDTH(TAB_WIDTH)
  ) u_top (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .char_code_i   (char_code),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .write_enable_o(write_enable),
    .write_col_o   (write_col),
    .write_row_o   (write_row),
    .write_char_o  (write_char),
    .write_attr_o  (write_attr),
    .scroll_up_o   (scroll_up),
    .cursor_col_o  (cursor_col),
    .cursor_row_o  (cursor_row),
    .cursor_pos_o  (cursor_pos)
  );

  assign dut_result = {write_enable, write_col, write_row, write_char, write_attr, scroll_up,
                       cursor_col, cursor_row, cursor_pos};

  always #5 clk = ~clk;

  // Idle lengths: mostly none or short, now and then long.
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [CHAR_W-1:0] pick_char();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 14) return CHAR_NEWLINE;
    if (r < 24) return CHAR_TAB;
    if (r < 34) return CHAR_BACKSPACE;
    if (r < 38) return CHAR_SPACE;
    return CHAR_W'($urandom_range(0, 255));
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  // Output monitor and stall pattern: quiet runs alternate with stalls of random length.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(dut_result);
    if (stall_left != 0) begin
      stall_left--;
    end else begin
      stall_on = !stall_on;
      if (stall_on) stall_left = gap_len() + 1;
      else if ($urandom_range(0, 99) < 70) stall_left = $urandom_range(1, 20);
      else stall_left = $urandom_range(30, 150);
    end
    out_stall <= stall_on;
  end

  task automatic send_char(input logic [CHAR_W-1:0] c, input int unsigned gap);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    char_code <= c;
    do @(posedge clk); while (in_stall);
    sb.note_char(c);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_attr_reg(input logic [ATTR_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.attr = value;
  endtask

  // Backspace at column 0 of row 0, wrap on print, backspace across a row, tab past the row
  // end, tab at an aligned column, tab from an unaligned one, and the byte extremes.
  logic [CHAR_W-1:0] directed_chars [NUM_DIRECTED] = '{
    CHAR_BACKSPACE, 8'h41, CHAR_BACKSPACE, CHAR_TAB, CHAR_TAB, 8'h00, CHAR_TAB, 8'hff,
    CHAR_BACKSPACE, CHAR_NEWLINE, 8'h7f, 8'h80, CHAR_SPACE, 8'h55, 8'haa
  };

  initial begin
    int unsigned       gap;
    int unsigned       burst_left;
    logic [CHAR_W-1:0] burst_char;
    logic [CHAR_W-1:0] c;
    sb = new();
    burst_left = 0;
    burst_char = CHAR_NEWLINE;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int d = 0; d < NUM_DIRECTED; d++) send_char(directed_chars[d], gap_len());

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p != 0) begin
        drain_results();
        case (p)
          1: write_attr_reg(8'h00);
          2: write_attr_reg(8'hff);
          default: write_attr_reg(ATTR_W'($urandom_range(0, 255)));
        endcase
      end
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        // Runs of newlines push the cursor to the bottom row and into scrolling; runs of
        // backspaces walk it back up across row boundaries.
        if (burst_left != 0) begin
          c = burst_char;
          burst_left--;
        end else if ($urandom_range(0, 99) < 4) begin
          burst_char = ($urandom_range(0, 2) == 0) ? CHAR_BACKSPACE : CHAR_NEWLINE;
          burst_left = (burst_char == CHAR_NEWLINE) ? $urandom_range(10, 30)
                                                    : $urandom_range(20, 90);
          c = burst_char;
        end else begin
          c = pick_char();
        end
        gap = ((i % 120) < 30) ? 0 : gap_len();
        send_char(c, gap);
      end
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending() != 0) sb.report("expected results left over at the end");
    if (sb.mismatches == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
